>>> design/nixie_two_digit_display_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-digit tube sequencer
// Clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NIXIE_TWO_DIGIT_DISPLAY_SEQUENCER_MACROS_SVH
`define NIXIE_TWO_DIGIT_DISPLAY_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define NXSEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NXSEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/nxseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nxseq_pkg
// Types, codes and helper functions shared by the tube sequencer files.
// ----------------------------------------------------------------------------
package nxseq_pkg;

    // Divider operand width and the fixed dividend of the counter step length
    localparam int          DIV_W          = 16;
    localparam logic [15:0] COUNT_MINUTE_MS = 16'd60000;

    // Anti-poisoning pass
    localparam logic [15:0] SCRUB_STEP_MS  = 16'd50;
    localparam logic [3:0]  SCRUB_STEPS    = 4'd10;
    localparam logic [3:0]  SCRUB_SAT      = 4'd15;
    localparam logic [3:0]  BLANK_DIGIT    = 4'd10;

    // Register indexes
    localparam logic [2:0] REG_CLOCK_MODE     = 3'd0;
    localparam logic [2:0] REG_COUNT_SPEED    = 3'd1;
    localparam logic [2:0] REG_FADE_SELECT    = 3'd2;
    localparam logic [2:0] REG_SCROLL_DIGITS  = 3'd3;
    localparam logic [2:0] REG_DIGIT_ON_MS    = 3'd4;
    localparam logic [2:0] REG_TWELVE_HOUR    = 3'd5;
    localparam logic [2:0] REG_DISPLAY_SELECT = 3'd6;
    localparam logic [2:0] REG_SHOW_SECONDS   = 3'd7;

    // Fade codes
    localparam logic [2:0] FADE_NONE       = 3'd0;
    localparam logic [2:0] FADE_NONE_DELAY = 3'd1;
    localparam logic [2:0] FADE_IN         = 3'd2;
    localparam logic [2:0] FADE_DOWN       = 3'd3;
    localparam logic [2:0] FADE_DOWN_UP    = 3'd4;

    // Display select codes
    localparam logic [1:0] DISP_TIME      = 2'd0;
    localparam logic [1:0] DISP_DAY_MONTH = 2'd1;

    // Colon masks
    localparam logic [1:0] COLON_OFF    = 2'd0;
    localparam logic [1:0] COLON_HOUR   = 2'd1;
    localparam logic [1:0] COLON_MINUTE = 2'd2;
    localparam logic [1:0] COLON_SECOND = 2'd3;

    // Clock display phases
    localparam logic [2:0] PH_HOUR   = 3'd0;
    localparam logic [2:0] PH_ODD1   = 3'd1;
    localparam logic [2:0] PH_MINUTE = 3'd2;
    localparam logic [2:0] PH_ODD3   = 3'd3;
    localparam logic [2:0] PH_SECOND = 3'd4;
    localparam logic [2:0] PH_ODD5   = 3'd5;
    localparam logic [2:0] PH_SCRUB  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    // Swapped-nibble BCD: units high, tens low
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] units;
        if (v >= 6'd60)      tens = 4'd6;
        else if (v >= 6'd50) tens = 4'd5;
        else if (v >= 6'd40) tens = 4'd4;
        else if (v >= 6'd30) tens = 4'd3;
        else if (v >= 6'd20) tens = 4'd2;
        else if (v >= 6'd10) tens = 4'd1;
        else                 tens = 4'd0;
        units = v - ({2'b00, tens} * 6'd10);
        return {units[3:0], tens};
    endfunction

    // x mod 10 for any 9-bit x through the reciprocal 205/2048
    function automatic logic [3:0] mod10(input logic [8:0] x);
        logic [16:0] prod;
        logic [8:0]  rem;
        prod = {8'b0, x} * 17'd205;
        rem  = x - ({3'b000, prod[16:11]} * 9'd10);
        return rem[3:0];
    endfunction

    // Phase step (phase + 2) mod 7
    function automatic logic [2:0] phase_adv(input logic [2:0] ph);
        logic [2:0] nx;
        case (ph)
            PH_HOUR:   nx = PH_MINUTE;
            PH_ODD1:   nx = PH_ODD3;
            PH_MINUTE: nx = PH_SECOND;
            PH_ODD3:   nx = PH_ODD5;
            PH_SECOND: nx = PH_SCRUB;
            PH_ODD5:   nx = PH_HOUR;
            PH_SCRUB:  nx = PH_ODD1;
            default:   nx = PH_MINUTE;
        endcase
        return nx;
    endfunction

endpackage

>>> design/nixie_two_digit_display_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nixie_two_digit_display_sequencer
// Drives a two-digit tube from millisecond ticks: digit counter or clock.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one tick beat: now_ms and the calendar fields. Every accepted
//   tick yields exactly one m_* beat with the digit and colon commands.
//   cfg_* writes one register per beat (index, data); cfg_ready is always
//   high. Write registers only while no tick is in flight.
// Sequence:
//   A tick is accepted only in idle. It is evaluated in S_EVAL and the
//   result is shown in S_OUT. A counter step in count mode first waits in
//   S_DIV while the serial divider computes the 60000/count_speed step
//   length. A new tick is accepted only after the result is taken.
// Reset:
//   rst_n clears registers to their defaults, clock mode, hour phase, an
//   empty timer so the first tick fires, and the snapshot to 1 Jan 00:00:00.
// Stall:
//   While m_tready is low the result holds and s_tready stays low.
// ----------------------------------------------------------------------------
module nixie_two_digit_display_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    // now_ms[31:0], cal_month[35:32], cal_day[40:36], cal_hour[45:41],
    // cal_minute[51:46], cal_second[57:52], zero fill [63:58]
    input  logic [63:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // digit_write[0], digit_value[8:1], fade_mode[11:9], colon_write[12],
    // colon_mask[14:13], zero fill [15]
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    nxseq_pkg::state_t state_reg, state_next;

    // configuration
    logic        clock_mode_reg;
    logic [15:0] count_speed_reg;
    logic [2:0]  fade_select_reg;
    logic        scroll_digits_reg;
    logic [15:0] digit_on_ms_reg;
    logic        twelve_hour_reg;
    logic [1:0]  display_select_reg;
    logic        show_seconds_reg;

    // latched tick
    logic [31:0] now_reg;
    logic [3:0]  in_month_reg;
    logic [4:0]  in_day_reg;
    logic [4:0]  in_hour_reg;
    logic [5:0]  in_minute_reg;
    logic [5:0]  in_second_reg;

    // sequencer state
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  scrub_reg, scrub_next;
    logic [7:0]  shown_reg, shown_next;
    logic [3:0]  snap_month_reg, snap_month_next;
    logic [4:0]  snap_day_reg, snap_day_next;
    logic [4:0]  snap_hour_reg, snap_hour_next;
    logic [5:0]  snap_minute_reg, snap_minute_next;
    logic [5:0]  snap_second_reg, snap_second_next;
    logic [31:0] tstart_reg, tstart_next;
    logic [15:0] tlen_reg, tlen_next;

    // result
    logic        dw_reg, dw_next;
    logic [7:0]  dv_reg, dv_next;
    logic [2:0]  fm_reg, fm_next;
    logic        cw_reg, cw_next;
    logic [1:0]  cm_reg, cm_next;

    logic        div_start;
    logic        div_done;
    logic [15:0] div_quo;

    logic [31:0] elapsed;
    logic        expired;
    logic [3:0]  inc_digit;
    logic [4:0]  hour_adj;
    logic        is_time;
    logic        day_first;
    logic [5:0]  val;
    logic [7:0]  bcd;
    logic [2:0]  ph_work;
    logic [3:0]  scrub_inc;
    logic [3:0]  scrub_digit;

    assign s_tready  = (state_reg == nxseq_pkg::S_IDLE);
    assign m_tvalid  = (state_reg == nxseq_pkg::S_OUT);
    assign m_tdata   = {1'b0, cm_reg, cw_reg, fm_reg, dv_reg, dw_reg};
    assign cfg_ready = 1'b1;

    nxseq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (nxseq_pkg::COUNT_MINUTE_MS),
        .divisor  (count_speed_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        elapsed   = now_reg - tstart_reg;
        expired   = (elapsed >= {16'b0, tlen_reg});
        inc_digit = nxseq_pkg::mod10({1'b0, shown_reg} + 9'd1);
        hour_adj  = (twelve_hour_reg && (snap_hour_reg > 5'd12)) ?
                    (snap_hour_reg - 5'd12) : snap_hour_reg;
        is_time   = (display_select_reg == nxseq_pkg::DISP_TIME);
        day_first = (display_select_reg == nxseq_pkg::DISP_DAY_MONTH);
        scrub_inc = (scrub_reg == nxseq_pkg::SCRUB_SAT) ? scrub_reg : (scrub_reg + 4'd1);
        scrub_digit = scroll_digits_reg ? inc_digit : nxseq_pkg::BLANK_DIGIT;

        state_next       = state_reg;
        phase_next       = phase_reg;
        scrub_next       = scrub_reg;
        shown_next       = shown_reg;
        snap_month_next  = snap_month_reg;
        snap_day_next    = snap_day_reg;
        snap_hour_next   = snap_hour_reg;
        snap_minute_next = snap_minute_reg;
        snap_second_next = snap_second_reg;
        tstart_next      = tstart_reg;
        tlen_next        = tlen_reg;
        dw_next          = dw_reg;
        dv_next          = dv_reg;
        fm_next          = fm_reg;
        cw_next          = cw_reg;
        cm_next          = cm_reg;
        div_start        = 1'b0;
        val              = '0;
        ph_work          = phase_reg;
        bcd              = '0;

        unique case (state_reg)
            nxseq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = nxseq_pkg::S_EVAL;
            end
            nxseq_pkg::S_EVAL:
            begin
                dw_next    = 1'b0;
                dv_next    = '0;
                fm_next    = nxseq_pkg::FADE_NONE;
                cw_next    = 1'b0;
                cm_next    = nxseq_pkg::COLON_OFF;
                state_next = nxseq_pkg::S_OUT;
                if (!clock_mode_reg)
                begin
                    cw_next = 1'b1;
                    if ((count_speed_reg != 16'd0) && expired)
                    begin
                        // step length comes back from the divider
                        tstart_next = now_reg;
                        div_start   = 1'b1;
                        state_next  = nxseq_pkg::S_DIV;
                        shown_next  = {4'b0, inc_digit};
                        dw_next     = 1'b1;
                        fm_next     = fade_select_reg;
                        dv_next     = {inc_digit, inc_digit};
                    end
                end
                else if (phase_reg == nxseq_pkg::PH_SCRUB)
                begin
                    if (expired)
                    begin
                        tstart_next = now_reg;
                        tlen_next   = nxseq_pkg::SCRUB_STEP_MS;
                        cw_next     = 1'b1;
                        dw_next     = 1'b1;
                        shown_next  = {4'b0, scrub_digit};
                        dv_next     = {scrub_digit, scrub_digit};
                        scrub_next  = scrub_inc;
                        if (scrub_inc >= nxseq_pkg::SCRUB_STEPS)
                        begin
                            // pass done: take a fresh snapshot
                            phase_next       = nxseq_pkg::PH_HOUR;
                            snap_month_next  = in_month_reg;
                            snap_day_next    = in_day_reg;
                            snap_hour_next   = in_hour_reg;
                            snap_minute_next = in_minute_reg;
                            snap_second_next = in_second_reg;
                            tlen_next        = '0;
                        end
                    end
                end
                else if (expired)
                begin
                    scrub_next  = '0;
                    fm_next     = fade_select_reg;
                    tstart_next = now_reg;
                    tlen_next   = digit_on_ms_reg;
                    case (phase_reg)
                        nxseq_pkg::PH_HOUR:
                        begin
                            cm_next = nxseq_pkg::COLON_HOUR;
                            if (fade_select_reg == nxseq_pkg::FADE_DOWN)
                                fm_next = nxseq_pkg::FADE_NONE_DELAY;
                            if (fade_select_reg == nxseq_pkg::FADE_DOWN_UP)
                                fm_next = nxseq_pkg::FADE_IN;
                            if (is_time)
                                val = {1'b0, hour_adj};
                            else if (day_first)
                                val = {1'b0, snap_day_reg};
                            else
                                val = {2'b00, snap_month_reg};
                        end
                        nxseq_pkg::PH_MINUTE:
                        begin
                            cm_next = nxseq_pkg::COLON_MINUTE;
                            if (is_time)
                            begin
                                val = snap_minute_reg;
                                if (!show_seconds_reg)
                                    ph_work = nxseq_pkg::PH_SECOND;
                            end
                            else
                            begin
                                val     = day_first ? {2'b00, snap_month_reg} :
                                                      {1'b0, snap_day_reg};
                                ph_work = nxseq_pkg::PH_SECOND;
                            end
                        end
                        nxseq_pkg::PH_SECOND:
                        begin
                            cm_next = nxseq_pkg::COLON_SECOND;
                            val     = snap_second_reg;
                        end
                        default:
                        begin
                            cm_next = nxseq_pkg::COLON_OFF;
                            val     = '0;
                        end
                    endcase
                    bcd        = nxseq_pkg::to_bcd(val);
                    dw_next    = 1'b1;
                    dv_next    = bcd;
                    cw_next    = 1'b1;
                    shown_next = (ph_work == nxseq_pkg::PH_SECOND) ? 8'd0 : bcd;
                    phase_next = nxseq_pkg::phase_adv(ph_work);
                end
            end
            nxseq_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    tlen_next  = div_quo;
                    state_next = nxseq_pkg::S_OUT;
                end
            end
            nxseq_pkg::S_OUT:
            begin
                if (m_tready)
                    state_next = nxseq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nxseq_pkg::S_IDLE;
            phase_reg       <= nxseq_pkg::PH_HOUR;
            scrub_reg       <= '0;
            shown_reg       <= '0;
            snap_month_reg  <= 4'd1;
            snap_day_reg    <= 5'd1;
            snap_hour_reg   <= '0;
            snap_minute_reg <= '0;
            snap_second_reg <= '0;
            tstart_reg      <= '0;
            tlen_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            scrub_reg       <= scrub_next;
            shown_reg       <= shown_next;
            snap_month_reg  <= snap_month_next;
            snap_day_reg    <= snap_day_next;
            snap_hour_reg   <= snap_hour_next;
            snap_minute_reg <= snap_minute_next;
            snap_second_reg <= snap_second_next;
            tstart_reg      <= tstart_next;
            tlen_reg        <= tlen_next;
        end
    end

    // payload: tick latch and result beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            now_reg       <= s_tdata[31:0];
            in_month_reg  <= s_tdata[35:32];
            in_day_reg    <= s_tdata[40:36];
            in_hour_reg   <= s_tdata[45:41];
            in_minute_reg <= s_tdata[51:46];
            in_second_reg <= s_tdata[57:52];
        end
        dw_reg <= dw_next;
        dv_reg <= dv_next;
        fm_reg <= fm_next;
        cw_reg <= cw_next;
        cm_reg <= cm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_mode_reg     <= 1'b1;
            count_speed_reg    <= '0;
            fade_select_reg    <= nxseq_pkg::FADE_NONE;
            scroll_digits_reg  <= 1'b0;
            digit_on_ms_reg    <= 16'd1000;
            twelve_hour_reg    <= 1'b0;
            display_select_reg <= nxseq_pkg::DISP_TIME;
            show_seconds_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nxseq_pkg::REG_CLOCK_MODE:     clock_mode_reg     <= cfg_data[0];
                nxseq_pkg::REG_COUNT_SPEED:    count_speed_reg    <= cfg_data;
                nxseq_pkg::REG_FADE_SELECT:    fade_select_reg    <= cfg_data[2:0];
                nxseq_pkg::REG_SCROLL_DIGITS:  scroll_digits_reg  <= cfg_data[0];
                nxseq_pkg::REG_DIGIT_ON_MS:    digit_on_ms_reg    <= cfg_data;
                nxseq_pkg::REG_TWELVE_HOUR:    twelve_hour_reg    <= cfg_data[0];
                nxseq_pkg::REG_DISPLAY_SELECT: display_select_reg <= cfg_data[1:0];
                nxseq_pkg::REG_SHOW_SECONDS:   show_seconds_reg   <= cfg_data[0];
                default:                       show_seconds_reg   <= show_seconds_reg;
            endcase
        end
    end

endmodule

>>> design/nxseq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nxseq_div
// Restoring divider, one quotient bit per cycle, done pulse after the last.
// ----------------------------------------------------------------------------
module nxseq_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nxseq_pkg::DIV_W-1:0] dividend,
    input  logic [nxseq_pkg::DIV_W-1:0] divisor,
    output logic                        done,
    output logic [nxseq_pkg::DIV_W-1:0] quotient
);

    localparam int                      CW   = $clog2(nxseq_pkg::DIV_W);
    localparam logic [CW-1:0]           LAST = CW'(nxseq_pkg::DIV_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [nxseq_pkg::DIV_W-1:0]   rem_reg;
    logic [nxseq_pkg::DIV_W-1:0]   quo_reg;
    logic [nxseq_pkg::DIV_W-1:0]   dsr_reg;
    logic [nxseq_pkg::DIV_W:0]     shifted;
    logic                          ge;
    logic [nxseq_pkg::DIV_W:0]     diff;
    logic [nxseq_pkg::DIV_W-1:0]   rem_next;
    logic [nxseq_pkg::DIV_W-1:0]   quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[nxseq_pkg::DIV_W-1]};
        ge       = (shifted >= {1'b0, dsr_reg});
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = ge ? diff[nxseq_pkg::DIV_W-1:0] : shifted[nxseq_pkg::DIV_W-1:0];
        quo_next = {quo_reg[nxseq_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/nxseq_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nxseq_chk
// Port-level checks on the tube sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "nixie_two_digit_display_sequencer_macros.svh"

module nxseq_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    // a stalled result beat holds
    `NXSEQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // no new tick while a result is pending
    `NXSEQ_ASSERT_NOW(a_one_in_flight, m_tvalid, !s_tready, "tick accepted with a result pending")

    // no digit sent: value and fade are zero
    `NXSEQ_ASSERT_NOW(a_no_digit_zero, m_tvalid && !m_tdata[0], m_tdata[11:1] == 11'd0, "digit fields set without digit_write")

    // every digit beat also sets the colons
    `NXSEQ_ASSERT_NOW(a_digit_colon, m_tvalid && m_tdata[0], m_tdata[12], "digit_write without colon_write")

endmodule

bind nixie_two_digit_display_sequencer nxseq_chk u_nxseq_chk (.*);
